/* design/ppi_pkg.sv */
package ppi_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_PIN   = 2'd2
  } ppi_cmd_e;

  localparam logic [1:0] PORT_A    = 2'd0;
  localparam logic [1:0] PORT_B    = 2'd1;
  localparam logic [1:0] PORT_C    = 2'd2;
  localparam logic [1:0] ADDR_CTRL = 2'd3;

  localparam logic CFG_CLEAR_ON_MODE_SET = 1'b0;
  localparam logic CFG_AUTO_HANDSHAKE    = 1'b1;

  localparam logic [1:0] MODE_A_BASIC  = 2'd0;
  localparam logic [1:0] MODE_A_STROBE = 2'd1;
  localparam logic [1:0] MODE_A_BIDIR  = 2'd2;

  localparam logic [7:0] IBF_A  = 8'h20;
  localparam logic [7:0] STB_A  = 8'h10;
  localparam logic [7:0] STB_B  = 8'h04;
  localparam logic [7:0] IBF_B  = 8'h02;
  localparam logic [7:0] OBF_A  = 8'h80;
  localparam logic [7:0] ACK_A  = 8'h40;
  localparam logic [7:0] ACK_B  = 8'h04;
  localparam logic [7:0] OBF_B  = 8'h02;
  localparam logic [7:0] INTR_A = 8'h08;
  localparam logic [7:0] INTR_B = 8'h01;

  localparam logic [7:0] MASK_ALL   = 8'hff;
  localparam logic [7:0] MASK_UPPER = 8'hf0;
  localparam logic [7:0] MASK_NONE  = 8'h00;

  typedef struct packed {
    logic [2:0][7:0] lat;
    logic [2:0]      fw;
    logic [2:0]      drv;
  } ppi_st_t;

endpackage

/* design/parallel_port_interface.sv */
// Channel   Direction  Handshake              Payload
// request   in         in_valid_i/in_stall_o  cmd, reg_addr, data_in, pin_mask, pin_port
// result    out        out_valid_o/out_stall_i read_data, port_a/b/c_drive, drive_changed
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One request per cycle while the result is not stalled; its result is registered in the cycle after acceptance.
// The port logic is a single combinational pass into that register.
// Reset clears latches, pin images, modes and config; input masks go to all ones.
// A stalled result holds the request channel off while the result register is full.
module parallel_port_interface
  import ppi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [1:0] reg_addr_i,
  input  logic [7:0] data_in_i,
  input  logic [7:0] pin_mask_i,
  input  logic [1:0] pin_port_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [7:0] port_a_drive_o,
  output logic [7:0] port_b_drive_o,
  output logic [7:0] port_c_drive_o,
  output logic [2:0] drive_changed_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic       cfg_data_i
);

  logic            clear_q, auto_q;
  logic [2:0][7:0] lat_q, lat_d;
  logic [2:0][7:0] pin_q, pin_d;
  logic [2:0][7:0] mask_q, mask_d;
  logic [2:0]      fw_q, fw_d;
  logic [1:0]      mode_a_q, mode_a_d;
  logic            mode_b_q, mode_b_d;
  logic            out_valid_q;
  logic [7:0]      rd_q, rd_d;
  logic [2:0]      drv_q, drv_d;
  logic            accept;

  function automatic ppi_st_t latch_wr(ppi_st_t st, logic [1:0] p, logic [7:0] v);
    ppi_st_t r;
    r = st;
    if (r.lat[p] != v || r.fw[p]) begin
      r.lat[p] = v;
      r.fw[p]  = 1'b0;
      r.drv[p] = 1'b1;
    end
    return r;
  endfunction

  function automatic ppi_st_t port_wr(ppi_st_t st, logic [1:0] p, logic [7:0] v,
                                      logic auto_hs, logic hs_a, logic hs_b);
    ppi_st_t    r;
    logic [7:0] c;
    logic [7:0] val;
    r = latch_wr(st, p, v);
    c = r.lat[PORT_C];
    val = c;
    if (!auto_hs) begin
      if (p == PORT_A && hs_a) begin
        val = c & ~OBF_A;
        if ((c & ACK_A) != MASK_NONE) val = val & ~INTR_A;
        r = latch_wr(r, PORT_C, val);
      end else if (p == PORT_B && hs_b) begin
        val = c & ~OBF_B;
        if ((c & ACK_B) != MASK_NONE) val = val & ~INTR_B;
        r = latch_wr(r, PORT_C, val);
      end
    end
    return r;
  endfunction

  function automatic ppi_st_t pin_edge(ppi_st_t st, logic [7:0] pin, logic [7:0] d,
                                       logic [7:0] m, logic [7:0] old,
                                       logic [7:0] lvl, logic [7:0] intr);
    ppi_st_t r;
    r = st;
    if ((m & pin) != MASK_NONE) begin
      if ((old & pin) != MASK_NONE && (d & pin) == MASK_NONE) begin
        r = latch_wr(r, PORT_C, r.lat[PORT_C] | lvl);
      end else if ((old & pin) == MASK_NONE && (d & pin) != MASK_NONE) begin
        if ((r.lat[PORT_C] & pin) != MASK_NONE) begin
          r = latch_wr(r, PORT_C, r.lat[PORT_C] | intr);
        end
      end
    end
    return r;
  endfunction

  always_comb begin
    ppi_st_t    st;
    logic       hs_a;
    logic       hs_b;
    logic [7:0] c;
    logic [7:0] val;
    st       = '{lat: lat_q, fw: fw_q, drv: 3'b000};
    pin_d    = pin_q;
    mask_d   = mask_q;
    mode_a_d = mode_a_q;
    mode_b_d = mode_b_q;
    rd_d     = MASK_NONE;
    hs_a     = (mode_a_q == MODE_A_STROBE) || (mode_a_q == MODE_A_BIDIR);
    hs_b     = mode_b_q;
    c        = lat_q[PORT_C];
    val      = c;
    case (cmd_i)
      CMD_WRITE: begin
        if (reg_addr_i == ADDR_CTRL) begin
          if (data_in_i[7]) begin
            mode_a_d = data_in_i[6] ? MODE_A_BIDIR : {1'b0, data_in_i[5]};
            mask_d[PORT_A] = (data_in_i[6] || data_in_i[4]) ? MASK_ALL : MASK_NONE;
            mode_b_d = data_in_i[2];
            mask_d[PORT_B] = data_in_i[1] ? MASK_ALL : MASK_NONE;
            mask_d[PORT_C] = {{4{data_in_i[3]}}, {4{data_in_i[0]}}};
            hs_a = (mode_a_d == MODE_A_STROBE) || (mode_a_d == MODE_A_BIDIR);
            hs_b = mode_b_d;
            if (clear_q) begin
              st = port_wr(st, PORT_A, MASK_NONE, auto_q, hs_a, hs_b);
              st = port_wr(st, PORT_B, MASK_NONE, auto_q, hs_a, hs_b);
              st = latch_wr(st, PORT_C, MASK_NONE);
            end
            if (mode_a_d != MODE_A_BASIC || mode_b_d) begin
              val = st.lat[PORT_C];
              if (hs_a) val = (val & ~IBF_A & ~INTR_A) | OBF_A;
              if (hs_b) begin
                if (mask_d[PORT_B] == MASK_ALL) val = val & ~IBF_B;
                else val = val | OBF_B;
                val = val & ~INTR_B;
              end
              st = latch_wr(st, PORT_C, val);
            end
          end else begin
            val[data_in_i[3:1]] = data_in_i[0];
            st = latch_wr(st, PORT_C, val);
          end
        end else begin
          st = port_wr(st, reg_addr_i, data_in_i, auto_q, hs_a, hs_b);
        end
      end
      CMD_READ: begin
        if (reg_addr_i == ADDR_CTRL) begin
          rd_d = MASK_ALL;
        end else begin
          if (reg_addr_i == PORT_A && hs_a) begin
            val = c & ~IBF_A;
            if ((c & STB_A) != MASK_NONE) val = val & ~INTR_A;
            st = latch_wr(st, PORT_C, val);
          end else if (reg_addr_i == PORT_B && hs_b) begin
            val = c & ~IBF_B;
            if ((c & STB_B) != MASK_NONE) val = val & ~INTR_B;
            st = latch_wr(st, PORT_C, val);
          end
          rd_d = (pin_q[reg_addr_i] & mask_q[reg_addr_i]) |
                 (st.lat[reg_addr_i] & ~mask_q[reg_addr_i]);
        end
      end
      CMD_PIN: begin
        if (pin_port_i == PORT_A || pin_port_i == PORT_B) begin
          pin_d[pin_port_i] = (pin_q[pin_port_i] & ~pin_mask_i) | (data_in_i & pin_mask_i);
          if (auto_q) begin
            if (pin_port_i == PORT_A && hs_a) begin
              val = c | IBF_A;
              if ((c & STB_A) != MASK_NONE) val = val | INTR_A;
              st = latch_wr(st, PORT_C, val);
            end else if (pin_port_i == PORT_B && hs_b) begin
              val = c | IBF_B;
              if ((c & STB_B) != MASK_NONE) val = val | INTR_B;
              st = latch_wr(st, PORT_C, val);
            end
          end
        end else if (pin_port_i == PORT_C) begin
          if (!auto_q) begin
            if (hs_a) begin
              st = pin_edge(st, STB_A, data_in_i, pin_mask_i, pin_q[PORT_C], IBF_A, INTR_A);
              st = pin_edge(st, ACK_A, data_in_i, pin_mask_i, pin_q[PORT_C], OBF_A, INTR_A);
            end
            if (hs_b) begin
              if (mask_q[PORT_B] == MASK_ALL) begin
                st = pin_edge(st, STB_B, data_in_i, pin_mask_i, pin_q[PORT_C], IBF_B, INTR_B);
              end else begin
                st = pin_edge(st, ACK_B, data_in_i, pin_mask_i, pin_q[PORT_C], OBF_B, INTR_B);
              end
            end
          end
          pin_d[PORT_C] = (pin_q[PORT_C] & ~pin_mask_i) | (data_in_i & pin_mask_i);
        end
      end
      default: begin
      end
    endcase
    lat_d = st.lat;
    fw_d  = st.fw;
    drv_d = st.drv;
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q     <= 1'b0;
      auto_q      <= 1'b0;
      lat_q       <= '0;
      pin_q       <= '0;
      mask_q      <= {3{MASK_ALL}};
      fw_q        <= 3'b111;
      mode_a_q    <= MODE_A_BASIC;
      mode_b_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_CLEAR_ON_MODE_SET) clear_q <= cfg_data_i;
        else auto_q <= cfg_data_i;
      end
      if (accept) begin
        lat_q    <= lat_d;
        pin_q    <= pin_d;
        mask_q   <= mask_d;
        fw_q     <= fw_d;
        mode_a_q <= mode_a_d;
        mode_b_q <= mode_b_d;
      end
      if (accept) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q  <= rd_d;
      drv_q <= drv_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rd_q;
  assign port_a_drive_o  = lat_q[PORT_A];
  assign port_b_drive_o  = lat_q[PORT_B];
  assign port_c_drive_o  = lat_q[PORT_C];
  assign drive_changed_o = drv_q;

endmodule
